[rtl/i2cee_pkg.sv]
// Package for the I2C EEPROM byte access master.
// Holds the sequencer state type, request kinds and configuration register map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cee_pkg;

  typedef enum logic [17:0] {
    PH_IDLE       = 18'b000000000000000001,
    PH_ST_SDA_HI  = 18'b000000000000000010,
    PH_ST_SCL_HI  = 18'b000000000000000100,
    PH_ST_SDA_LO  = 18'b000000000000001000,
    PH_WB_SCL_LO  = 18'b000000000000010000,
    PH_WB_SDA_BIT = 18'b000000000000100000,
    PH_WB_SCL_HI  = 18'b000000000001000000,
    PH_WE_SCL_LO  = 18'b000000000010000000,
    PH_WE_SDA_HI  = 18'b000000000100000000,
    PH_ACK_SCL_HI = 18'b000000001000000000,
    PH_ACK_WAIT   = 18'b000000010000000000,
    PH_RB_SCL_LO  = 18'b000000100000000000,
    PH_RB_SDA_HI  = 18'b000001000000000000,
    PH_RB_SCL_HI  = 18'b000010000000000000,
    PH_RB_SAMPLE  = 18'b000100000000000000,
    PH_SP_SDA_LO  = 18'b001000000000000000,
    PH_SP_SCL_HI  = 18'b010000000000000000,
    PH_SP_SDA_HI  = 18'b100000000000000000
  } phase_t;

  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_ACK_WAIT_LIMIT = 2'd1;

  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;
  localparam logic [7:0] ACK_WAIT_LIMIT_RESET = 8'd250;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic [2:0] SEG_START      = 3'd0;
  localparam logic [2:0] SEG_DEV_WRITE  = 3'd1;
  localparam logic [2:0] SEG_WORD_ADDR  = 3'd2;
  localparam logic [2:0] SEG_THIRD      = 3'd3;
  localparam logic [2:0] SEG_DEV_READ   = 3'd4;
  localparam logic [2:0] SEG_READ_BYTE  = 3'd5;

endpackage

`default_nettype wire

[rtl/i2c_eeprom_byte_access_master_top.sv]
// Top level of the I2C EEPROM byte access master: tick stage, pin sequencer, result register.
// Depends on i2cee_pkg.
//
// Each input beat is one tick of the bus sequencer and yields exactly one result beat
// carrying the SCL/SDA levels, busy/done flags and the last read byte. A beat is taken
// into an input register, advanced through one step of the sequencer and written into
// the result register once it is free, so one beat per clock is sustained while the
// result is not stalled; the single-step state update is the only loop. A stalled
// result register still lets one more beat into the input register. A byte write takes
// 6 + 3*(27 + ack ticks) ticks; a random read sends, in place of the data byte, a
// repeated start, a second address byte and 8 sampled bits.
`timescale 1ns / 1ps
`default_nettype none

module i2c_eeprom_byte_access_master_top import i2cee_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] word_address,
  input  wire logic [7:0] write_data,
  input  wire logic       sda_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            scl_out,
  output logic            sda_out,
  output logic            busy_res,
  output logic            done_res,
  output logic [7:0]      read_data
);

  logic [6:0] device_address;
  logic [7:0] ack_wait_limit;

  logic       stg_valid;
  logic [1:0] stg_kind;
  logic [7:0] stg_word_address;
  logic [7:0] stg_write_data;
  logic       stg_sda_in;

  phase_t     phase, phase_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] wait_count, wait_count_next;
  logic       is_read, is_read_next;
  logic [7:0] held_address, held_address_next;
  logic [7:0] held_data, held_data_next;
  logic [7:0] received_byte, received_byte_next;
  logic [2:0] segment, segment_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       done_next;

  logic       seg_go;
  logic [2:0] seg_num;
  logic [3:0] bit_inc;
  logic [7:0] dev_byte;
  logic       step_fire;

  assign cfg_ready = 1'b1;
  assign step_fire = stg_valid && (!out_valid || out_ready);
  assign in_ready  = !stg_valid || step_fire;
  assign bit_inc   = bit_index + 4'd1;
  assign dev_byte  = {device_address, 1'b0};
  assign seg_num   = segment + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RESET;
      ack_wait_limit <= ACK_WAIT_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        CFG_ACK_WAIT_LIMIT: ack_wait_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_valid <= 1'b1;
    end else if (step_fire) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_kind         <= kind;
      stg_word_address <= word_address;
      stg_write_data   <= write_data;
      stg_sda_in       <= sda_in;
    end
  end

  always_comb begin
    phase_next         = phase;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    wait_count_next    = wait_count;
    is_read_next       = is_read;
    held_address_next  = held_address;
    held_data_next     = held_data;
    received_byte_next = received_byte;
    segment_next       = segment;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    done_next          = 1'b0;
    seg_go             = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (stg_kind == KIND_WRITE || stg_kind == KIND_READ) begin
          is_read_next      = (stg_kind == KIND_READ);
          held_address_next = stg_word_address;
          held_data_next    = stg_write_data;
          segment_next      = SEG_START;
          sda_level_next    = 1'b1;
          phase_next        = PH_ST_SCL_HI;
        end
      end
      PH_ST_SDA_HI: begin
        sda_level_next = 1'b1;
        phase_next     = PH_ST_SCL_HI;
      end
      PH_ST_SCL_HI: begin
        scl_level_next = 1'b1;
        phase_next     = PH_ST_SDA_LO;
      end
      PH_ST_SDA_LO: begin
        sda_level_next = 1'b0;
        seg_go         = 1'b1;
      end
      PH_WB_SCL_LO: begin
        scl_level_next = 1'b0;
        phase_next     = PH_WB_SDA_BIT;
      end
      PH_WB_SDA_BIT: begin
        sda_level_next  = shift_byte[7];
        shift_byte_next = {shift_byte[6:0], 1'b0};
        phase_next      = PH_WB_SCL_HI;
      end
      PH_WB_SCL_HI: begin
        scl_level_next = 1'b1;
        bit_index_next = bit_inc;
        phase_next     = (bit_inc >= BITS_PER_BYTE) ? PH_WE_SCL_LO : PH_WB_SCL_LO;
      end
      PH_WE_SCL_LO: begin
        scl_level_next = 1'b0;
        phase_next     = PH_WE_SDA_HI;
      end
      PH_WE_SDA_HI: begin
        sda_level_next = 1'b1;
        phase_next     = PH_ACK_SCL_HI;
      end
      PH_ACK_SCL_HI: begin
        scl_level_next  = 1'b1;
        wait_count_next = '0;
        phase_next      = PH_ACK_WAIT;
      end
      PH_ACK_WAIT: begin
        if (stg_sda_in && wait_count < ack_wait_limit) begin
          wait_count_next = wait_count + 8'd1;
        end else begin
          scl_level_next = 1'b0;
          seg_go         = 1'b1;
        end
      end
      PH_RB_SCL_LO: begin
        scl_level_next = 1'b0;
        phase_next     = PH_RB_SDA_HI;
      end
      PH_RB_SDA_HI: begin
        sda_level_next = 1'b1;
        phase_next     = PH_RB_SCL_HI;
      end
      PH_RB_SCL_HI: begin
        scl_level_next = 1'b1;
        phase_next     = PH_RB_SAMPLE;
      end
      PH_RB_SAMPLE: begin
        shift_byte_next = {shift_byte[6:0], stg_sda_in};
        scl_level_next  = 1'b0;
        bit_index_next  = bit_inc;
        if (bit_inc >= BITS_PER_BYTE) begin
          seg_go = 1'b1;
        end else begin
          phase_next = PH_RB_SCL_HI;
        end
      end
      PH_SP_SDA_LO: begin
        sda_level_next = 1'b0;
        phase_next     = PH_SP_SCL_HI;
      end
      PH_SP_SCL_HI: begin
        scl_level_next = 1'b1;
        phase_next     = PH_SP_SDA_HI;
      end
      PH_SP_SDA_HI: begin
        sda_level_next = 1'b1;
        if (is_read) begin
          received_byte_next = shift_byte;
        end
        phase_next = PH_IDLE;
        done_next  = 1'b1;
      end
      default: phase_next = PH_IDLE;
    endcase

    if (seg_go) begin
      segment_next = seg_num;
      case (seg_num)
        SEG_DEV_WRITE: begin
          shift_byte_next = dev_byte;
          bit_index_next  = '0;
          phase_next      = PH_WB_SCL_LO;
        end
        SEG_WORD_ADDR: begin
          shift_byte_next = held_address;
          bit_index_next  = '0;
          phase_next      = PH_WB_SCL_LO;
        end
        SEG_THIRD: begin
          if (is_read) begin
            phase_next = PH_ST_SDA_HI;
          end else begin
            shift_byte_next = held_data;
            bit_index_next  = '0;
            phase_next      = PH_WB_SCL_LO;
          end
        end
        SEG_DEV_READ: begin
          if (is_read) begin
            shift_byte_next = dev_byte | 8'd1;
            bit_index_next  = '0;
            phase_next      = PH_WB_SCL_LO;
          end else begin
            phase_next = PH_SP_SDA_LO;
          end
        end
        SEG_READ_BYTE: begin
          if (is_read) begin
            shift_byte_next = '0;
            bit_index_next  = '0;
            phase_next      = PH_RB_SCL_LO;
          end else begin
            phase_next = PH_SP_SDA_LO;
          end
        end
        default: phase_next = PH_SP_SDA_LO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_index     <= '0;
      shift_byte    <= '0;
      wait_count    <= '0;
      is_read       <= 1'b0;
      held_address  <= '0;
      held_data     <= '0;
      received_byte <= '0;
      segment       <= SEG_START;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
    end else if (step_fire) begin
      phase         <= phase_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      wait_count    <= wait_count_next;
      is_read       <= is_read_next;
      held_address  <= held_address_next;
      held_data     <= held_data_next;
      received_byte <= received_byte_next;
      segment       <= segment_next;
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      scl_out   <= scl_level_next;
      sda_out   <= sda_level_next;
      busy_res  <= (phase_next != PH_IDLE);
      done_res  <= done_next;
      read_data <= received_byte_next;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  a_idle_lines_released: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> scl_level && sda_level)
    else $error("bus lines not released while idle");

  a_bit_index_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= BITS_PER_BYTE)
    else $error("bit index past one byte");

  a_ack_wait_bound: assert property (@(posedge clk) disable iff (rst)
    step_fire && phase == PH_ACK_WAIT && wait_count >= ack_wait_limit
      |=> phase != PH_ACK_WAIT)
    else $error("acknowledge wait exceeded limit");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stg_valid && !step_fire |=> stg_valid)
    else $error("staged tick dropped before use");

endmodule

`default_nettype wire
